// ----- sv/actr_pkg.sv -----
package actr_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int BLOCK_W     = 128;
   localparam int HALF_W      = 64;
   localparam int CNT_W       = 5;
   localparam int TDATA_W     = 136;
   localparam int RND_W       = 4;
   localparam int CSR_IDX_W   = 2;

   localparam logic [RND_W-1:0]     LAST_ROUND   = 4'd10;
   localparam logic [CNT_W-1:0]     FULL_COUNT   = 5'd16;
   localparam logic [7:0]           GF_POLY      = 8'h1B;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_HIGH  = 2'd2;

   typedef logic [BLOCK_W-1:0] block_type;

   typedef struct packed {
      logic [7:0] rcon;
      logic       last;
   } rnd_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] sbox(input logic [7:0] b);
      return SBOX[b];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   // round constant used to derive the key of the given round
   function automatic logic [7:0] rcon(input logic [RND_W-1:0] rnd);
      logic [7:0] rc;
      unique case (rnd)
         4'd1:    rc = 8'h01;
         4'd2:    rc = 8'h02;
         4'd3:    rc = 8'h04;
         4'd4:    rc = 8'h08;
         4'd5:    rc = 8'h10;
         4'd6:    rc = 8'h20;
         4'd7:    rc = 8'h40;
         4'd8:    rc = 8'h80;
         4'd9:    rc = 8'h1b;
         4'd10:   rc = 8'h36;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

endpackage

// ----- sv/actr_round.sv -----
module actr_round (
   input  actr_pkg::block_type   blk,
   input  actr_pkg::block_type   rk,
   input  actr_pkg::rnd_ctl_type ctl,
   output actr_pkg::block_type   blk_out,
   output actr_pkg::block_type   rk_out
);
   import actr_pkg::*;

   logic [7:0] s   [BLOCK_BYTES];
   logic [7:0] t   [BLOCK_BYTES];
   logic [7:0] m   [BLOCK_BYTES];
   logic [31:0] w   [4];
   logic [31:0] n   [4];
   logic [31:0] tw;
   logic [7:0] all [4];
   block_type  mixed;

   // next round key, one key schedule step
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         w[c] = rk[BLOCK_W-1-32*c -: 32];
      end
      tw = {sbox(w[3][23:16]) ^ ctl.rcon, sbox(w[3][15:8]), sbox(w[3][7:0]),
            sbox(w[3][31:24])};
      n[0] = w[0] ^ tw;
      n[1] = w[1] ^ n[0];
      n[2] = w[2] ^ n[1];
      n[3] = w[3] ^ n[2];
      rk_out = {n[0], n[1], n[2], n[3]};
   end

   // sub bytes, shift rows, mix columns (skipped in the last round), add round key
   always_comb begin
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         s[k] = blk[BLOCK_W-1-8*k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[c*4+r] = sbox(s[((c + r) % 4)*4 + r]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         all[c]    = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
         m[c*4]    = t[c*4]   ^ all[c] ^ xtime(t[c*4]   ^ t[c*4+1]);
         m[c*4+1]  = t[c*4+1] ^ all[c] ^ xtime(t[c*4+1] ^ t[c*4+2]);
         m[c*4+2]  = t[c*4+2] ^ all[c] ^ xtime(t[c*4+2] ^ t[c*4+3]);
         m[c*4+3]  = t[c*4+3] ^ all[c] ^ xtime(t[c*4+3] ^ t[c*4]);
      end
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         mixed[BLOCK_W-1-8*k -: 8] = ctl.last ? t[k] : m[k];
      end
      blk_out = mixed ^ rk_out;
   end

endmodule

// ----- sv/aes128_ctr_keystream_xor.sv -----
// AES-128 counter mode: each request carries one 16-byte block that is
// XORed with one keystream block; one response comes back per request.
// The counter block is the 8 IV bytes followed by the block index, least
// significant index byte first. The index restarts at zero when the
// request's tuser flag is set and rises by one after every block.
// Bytes past the request's byte count (clamped to 16) come out as zero.
// Keys and IV are written on the csr port (0 key high, 1 key low,
// 2 IV high); the user must see that they are written only while no
// request is in flight, as the block does not enforce it. Round keys
// are derived on the fly from the key registers. The initial key
// addition is done as the request is taken, then ten rounds run on a
// single shared round unit. A new request is taken the cycle after the
// result moves into the response register, so only one block is in
// flight at a time.
// If the response is stalled, the response register holds it and a
// finished block waits in the round unit until that register frees.
// Reset clears the key, IV, block index and all valid flags.
module aes128_ctr_keystream_xor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // data_high, data_low, byte_count, zero pad
   input  logic [actr_pkg::TDATA_W-1:0]     req_tdata,
   // new_message
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_high, out_low, out_count, zero pad
   output logic [actr_pkg::TDATA_W-1:0]     rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [actr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [actr_pkg::HALF_W-1:0]      csr_wr_data
);
   import actr_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type         state_ff, state_in;
   logic [HALF_W-1:0] key_high_ff, key_high_in;
   logic [HALF_W-1:0] key_low_ff, key_low_in;
   logic [HALF_W-1:0] iv_ff, iv_in;
   logic [HALF_W-1:0] index_ff, index_in;
   logic [RND_W-1:0]  rnd_ff, rnd_in;
   block_type         blk_ff, blk_in;
   block_type         rk_ff, rk_in;
   block_type         data_ff, data_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   block_type         rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic              accept;
   logic              done;
   logic              out_free;
   logic [HALF_W-1:0] idx_sel;
   logic [HALF_W-1:0] ctr_low;
   block_type         key0;
   logic [CNT_W-1:0]  req_cnt;
   rnd_ctl_type       rnd_ctl;
   block_type         rnd_blk;
   block_type         rnd_rk;
   block_type         result;

   actr_round u_round (
      .blk     (blk_ff),
      .rk      (rk_ff),
      .ctl     (rnd_ctl),
      .blk_out (rnd_blk),
      .rk_out  (rnd_rk)
   );

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign rnd_ctl.rcon = rcon(rnd_ff);
   assign rnd_ctl.last = (rnd_ff == LAST_ROUND);
   assign done         = (state_ff == ST_RUN) && (rnd_ff == LAST_ROUND);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign key0         = {key_high_ff, key_low_ff};
   assign idx_sel      = req_tuser[0] ? '0 : index_ff;
   assign req_cnt      = (req_tdata[2*HALF_W +: CNT_W] > FULL_COUNT) ?
                         FULL_COUNT : req_tdata[2*HALF_W +: CNT_W];

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         ctr_low[HALF_W-1-8*j -: 8] = idx_sel[8*j +: 8];
      end
      for (int j = 0; j < BLOCK_BYTES; j++) begin
         result[BLOCK_W-1-8*j -: 8] = (CNT_W'(j) < cnt_ff) ?
            (data_ff[BLOCK_W-1-8*j -: 8] ^ rnd_blk[BLOCK_W-1-8*j -: 8]) : 8'h00;
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_high_in  = key_high_ff;
      key_low_in   = key_low_ff;
      iv_in        = iv_ff;
      index_in     = index_ff;
      rnd_in       = rnd_ff;
      blk_in       = blk_ff;
      rk_in        = rk_ff;
      data_in      = data_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_wr_data;
            CSR_KEY_LOW:  key_low_in  = csr_wr_data;
            CSR_IV_HIGH:  iv_in       = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               blk_in   = {iv_ff, ctr_low} ^ key0;
               rk_in    = key0;
               rnd_in   = RND_W'(1);
               data_in  = {req_tdata[HALF_W-1:0], req_tdata[HALF_W +: HALF_W]};
               cnt_in   = req_cnt;
               index_in = idx_sel + HALF_W'(1);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!done) begin
               blk_in = rnd_blk;
               rk_in  = rnd_rk;
               rnd_in = rnd_ff + RND_W'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               rsp_cnt_in   = cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         iv_ff        <= '0;
         index_ff     <= '0;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
         iv_ff        <= iv_in;
         index_ff     <= index_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_ff      <= blk_in;
      rk_ff       <= rk_in;
      data_ff     <= data_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W-BLOCK_W-CNT_W){1'b0}}, rsp_cnt_ff,
                        rsp_data_ff[HALF_W-1:0], rsp_data_ff[BLOCK_W-1 -: HALF_W]};

   a_accept_starts_round1: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (rnd_ff == RND_W'(1)))
      else $error("request did not start the first round");

   a_rsp_after_last_round: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done))
      else $error("response appeared before the last round");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && !done |=> (state_ff == ST_RUN))
      else $error("round sequence left early");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cnt_ff <= FULL_COUNT))
      else $error("response count above block size");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import actr_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [7:0] GF_REDUCE = 8'h1b;
   localparam logic [7:0] AFFINE_C  = 8'h63;
   localparam int LATENCY = 11;

   typedef struct packed {
      logic [HALF_W-1:0] out_high;
      logic [HALF_W-1:0] out_low;
      logic [CNT_W-1:0]  out_count;
   } cipher_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [HALF_W-1:0] csr_wr_data = '0;

   aes128_ctr_keystream_xor dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [7:0]  sub_byte [256];
   logic [31:0] round_key [44];
   logic [63:0] key_hi = '0;
   logic [63:0] key_lo = '0;
   logic [63:0] iv_reg = '0;
   logic [63:0] blk_index = '0;

   cipher_out_type cipher_out_q [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int n_sent = 0;
   int n_writes = 0;
   int n_fail = 0;

   initial forever #2 clock = ~clock;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
      end
      return p;
   endfunction

   // multiplicative inverse as x^254, then the affine map
   function automatic logic [7:0] sbox_entry(input logic [7:0] x);
      logic [7:0] inv;
      inv = 8'h01;
      for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
      return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] t;
      logic [7:0] rc;
      rc = 8'h01;
      round_key[0] = key_hi[63:32];
      round_key[1] = key_hi[31:0];
      round_key[2] = key_lo[63:32];
      round_key[3] = key_lo[31:0];
      for (int i = 4; i < 44; i++) begin
         t = round_key[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sub_byte[t[31:24]], sub_byte[t[23:16]], sub_byte[t[15:8]], sub_byte[t[7:0]]}
               ^ {rc, 24'h000000};
            rc = gf_mul(rc, 8'h02);
         end
         round_key[i] = round_key[i-4] ^ t;
      end
   endfunction

   function automatic cipher_out_type ctr_xor_result(input logic [63:0] dh,
                                                     input logic [63:0] dl,
                                                     input logic [4:0] cnt, input logic nm);
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] a0, a1, a2, a3, col_xor, db;
      logic [31:0] w;
      logic [63:0] oh, ol;
      logic [4:0] n;
      cipher_out_type r;
      n = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
      if (nm) blk_index = '0;
      for (int j = 0; j < 8; j++) begin
         st[j] = iv_reg[63-8*j -: 8];
         st[8+j] = blk_index[8*j +: 8];
      end
      for (int rnd = 0; rnd <= 10; rnd++) begin
         if (rnd != 0) begin
            for (int c = 0; c < 4; c++)
               for (int rw = 0; rw < 4; rw++)
                  tmp[c*4+rw] = sub_byte[st[((c+rw)%4)*4+rw]];
            if (rnd != 10) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = tmp[c*4];
                  a1 = tmp[c*4+1];
                  a2 = tmp[c*4+2];
                  a3 = tmp[c*4+3];
                  col_xor = a0 ^ a1 ^ a2 ^ a3;
                  st[c*4]   = a0 ^ col_xor ^ gf_mul(a0 ^ a1, 8'h02);
                  st[c*4+1] = a1 ^ col_xor ^ gf_mul(a1 ^ a2, 8'h02);
                  st[c*4+2] = a2 ^ col_xor ^ gf_mul(a2 ^ a3, 8'h02);
                  st[c*4+3] = a3 ^ col_xor ^ gf_mul(a3 ^ a0, 8'h02);
               end
            end else begin
               for (int k = 0; k < 16; k++) st[k] = tmp[k];
            end
         end
         for (int c = 0; c < 4; c++) begin
            w = round_key[rnd*4+c];
            st[c*4]   ^= w[31:24];
            st[c*4+1] ^= w[23:16];
            st[c*4+2] ^= w[15:8];
            st[c*4+3] ^= w[7:0];
         end
      end
      blk_index = blk_index + 64'd1;
      oh = '0;
      ol = '0;
      for (int j = 0; j < 16; j++) begin
         db = (j < 8) ? dh[63-8*j -: 8] : dl[63-8*(j-8) -: 8];
         db = (j < n) ? (db ^ st[j]) : 8'h00;
         if (j < 8) oh[63-8*j -: 8] = db;
         else ol[63-8*(j-8) -: 8] = db;
      end
      r.out_high = oh;
      r.out_low = ol;
      r.out_count = n;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_KEY_HIGH: begin
            key_hi = value;
            expand_round_keys();
         end
         CSR_KEY_LOW: begin
            key_lo = value;
            expand_round_keys();
         end
         CSR_IV_HIGH: iv_reg = value;
         default: ;
      endcase
      n_writes++;
   endtask

   task automatic send_block(input logic [63:0] dh, input logic [63:0] dl,
                             input logic [4:0] cnt, input logic nm);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, cnt, dl, dh};
      req_tuser <= nm;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cipher_out_q.insert(cipher_out_q.size(), ctr_xor_result(dh, dl, cnt, nm));
      n_sent++;
   endtask

   task automatic wait_responses();
      req_tvalid <= 1'b0;
      while (cipher_out_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic send_message(input int blocks);
      logic [4:0] cnt;
      for (int b = 0; b < blocks; b++) begin
         cnt = FULL_COUNT;
         if (b == blocks - 1 && $urandom_range(1) == 1) cnt = 5'($urandom_range(16, 1));
         send_block(rand64(), rand64(), cnt, b == 0);
      end
   endtask

   task automatic check_response();
      cipher_out_type exp_r;
      if (cipher_out_q.size() == 0) begin
         $error("response with no request outstanding: %h", rsp_tdata);
         n_fail++;
      end else begin
         exp_r = cipher_out_q.pop_front();
         if (rsp_tdata[63:0] !== exp_r.out_high) begin
            $error("out_high: expected %h, actual %h", exp_r.out_high, rsp_tdata[63:0]);
            n_fail++;
         end
         if (rsp_tdata[127:64] !== exp_r.out_low) begin
            $error("out_low: expected %h, actual %h", exp_r.out_low, rsp_tdata[127:64]);
            n_fail++;
         end
         if (rsp_tdata[132:128] !== exp_r.out_count) begin
            $error("out_count: expected %0d, actual %0d", exp_r.out_count, rsp_tdata[132:128]);
            n_fail++;
         end
      end
   endtask

   initial forever begin
      @(posedge clock);
      if (rsp_tvalid === 1'b1 && rsp_tready) check_response();
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic test_reset_defaults();
      send_block(64'h0, 64'h0, FULL_COUNT, 1'b0);
      send_block('1, '1, FULL_COUNT, 1'b0);
      wait_responses();
   endtask

   task automatic test_byte_counts();
      logic [4:0] counts [8] = '{5'd0, 5'd1, 5'd8, 5'd9, 5'd15, 5'd16, 5'd17, 5'd31};
      write_reg(CSR_KEY_HIGH, 64'h0001020304050607);
      write_reg(CSR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      write_reg(CSR_IV_HIGH, 64'h0011223344556677);
      for (int i = 0; i < 8; i++) send_block('1, '1, counts[i], i == 0);
      // restart in the middle of a message
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, FULL_COUNT, 1'b1);
      send_block(64'h0, 64'h0, FULL_COUNT, 1'b0);
      wait_responses();
   endtask

   task automatic test_register_extremes();
      write_reg(CSR_KEY_HIGH, '1);
      write_reg(CSR_KEY_LOW, '1);
      write_reg(CSR_IV_HIGH, '1);
      // unused index, must leave key and iv alone
      write_reg(CSR_SPARE, rand64());
      send_block({32{2'b10}}, {32{2'b01}}, FULL_COUNT, 1'b1);
      send_block({32{2'b01}}, {32{2'b10}}, FULL_COUNT, 1'b0);
      send_block('1, 64'h0, 5'd12, 1'b0);
      wait_responses();
   endtask

   task automatic test_random_traffic(input int s_idle, input int r_idle, input int items,
                                      input logic [63:0] kh, input logic [63:0] kl,
                                      input logic [63:0] iv);
      int target;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      write_reg(CSR_KEY_HIGH, kh);
      write_reg(CSR_KEY_LOW, kl);
      write_reg(CSR_IV_HIGH, iv);
      target = n_sent + items;
      while (n_sent < target) begin
         if ($urandom_range(9) < 8) begin
            send_message($urandom_range(12, 1));
         end else begin
            repeat ($urandom_range(4, 1))
               send_block(rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom_range(1)));
         end
         if ($urandom_range(19) == 0) wait_responses();
      end
      wait_responses();
   endtask

   task automatic test_long_message();
      write_reg(CSR_IV_HIGH, rand64());
      send_message(260);
      wait_responses();
   endtask

   task automatic test_output_stall();
      hold_cycles = 400;
      repeat (12) send_block(rand64(), rand64(), 5'($urandom_range(16, 1)), 1'b0);
      wait_responses();
   endtask

   initial begin
      for (int i = 0; i < 256; i++) sub_byte[i] = sbox_entry(8'(i));
      expand_round_keys();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 80;
      test_reset_defaults();
      test_byte_counts();
      test_register_extremes();
      test_random_traffic(37, 80, 250, rand64(), rand64(), rand64());
      test_random_traffic(80, 37, 250, rand64(), rand64(), rand64());
      test_random_traffic(0, 0, 150, 64'h0, 64'h0, 64'h0);
      test_long_message();
      test_output_stall();
      repeat (3 * LATENCY) @(posedge clock);
      $display("%0d requests checked across %0d register writes", n_sent, n_writes);
      $display("byte counts 0 to 31, message restarts, long runs and stalls on both sides");
      if (n_fail == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
